FILE: hw/rtl/stb_pkg.sv
`timescale 1ns / 1ps

package stb_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 3;
  localparam int TIME_W    = 32;
  localparam int MASK_W    = 8;

  localparam int IN_BITS   = CMD_W + SLOT_W + 2 * TIME_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W     = MASK_W;

  // slot memory word: reference in the upper half, period in the lower half
  localparam int WORD_W    = 2 * TIME_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_PERIODIC = 2'd1,
    CMD_ONE_SHOT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SUB,
    ST_UPDATE,
    ST_FINISH
  } state_e;

endpackage

FILE: hw/rtl/stb_ram.sv
`timescale 1ns / 1ps

module stb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/software_timer_bank.sv
`timescale 1ns / 1ps
// one item at a time; a tick walks the slots through one shared 32-bit adder and
// comparator, each slot in turn taking a memory read, the elapsed time and an update
// reset: asynchronous, active low; every slot comes up disabled and in one-shot mode,
// slot storage is marked empty by per-slot valid flops so no clearing pass is needed
module software_timer_bank (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // command[1:0], slot[4:2], period_ms[36:5], now_ms[68:37], zero pad
  input  logic [stb_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // fired_mask[7:0]
  output logic [stb_pkg::OUT_W-1:0] m_axis_tdata
);
  import stb_pkg::*;

  state_e state_q, state_d;

  cmd_e              cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] period_q;
  logic [TIME_W-1:0] now_q;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;

  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [NUM_SLOTS-1:0] one_shot_q, one_shot_d;

  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  logic              s_accept;
  logic              slot_in_range;
  logic [IDX_W-1:0]  slot_idx;
  logic              last_idx;
  logic              hit;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [TIME_W-1:0] rd_period, rd_reference;

  // shared adder
  logic [TIME_W-1:0] add_a, add_b, add_sum;
  logic              add_cin;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign slot_in_range = 32'(slot_q) < NUM_SLOTS;
  assign slot_idx      = IDX_W'(32'(slot_q));
  assign last_idx      = idx_q == IDX_W'(NUM_SLOTS - 1);
  assign rd_period     = ram_rdata[TIME_W-1:0];
  assign rd_reference  = ram_rdata[WORD_W-1:TIME_W];

  assign add_sum = add_a + add_b + TIME_W'(add_cin);

  // an entry never written reads as disabled
  assign hit = (state_q == ST_UPDATE) && valid_q[idx_q] && (rd_period != '0)
               && (elapsed_q > rd_period);

  always_comb begin
    add_a   = rd_reference;
    add_b   = rd_period;
    add_cin = 1'b0;
    if (state_q == ST_SUB) begin
      add_a   = now_q;
      add_b   = ~rd_reference;
      add_cin = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          case (cmd_e'(s_axis_tdata[CMD_W-1:0]))
            CMD_TICK:     state_d = ST_READ;
            CMD_PERIODIC: state_d = ST_WRITE;
            CMD_ONE_SHOT: state_d = ST_WRITE;
            default:      state_d = ST_FINISH;
          endcase
        end
      end
      ST_WRITE:  state_d = ST_FINISH;
      ST_READ:   state_d = ST_SUB;
      ST_SUB:    state_d = ST_UPDATE;
      ST_UPDATE: state_d = last_idx ? ST_FINISH : ST_READ;
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    mask_d      = mask_q;
    elapsed_d   = elapsed_q;
    valid_d     = valid_q;
    one_shot_d  = one_shot_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {add_sum, rd_period};

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        idx_d  = '0;
        mask_d = '0;
      end
      ST_WRITE: begin
        if (slot_in_range) begin
          ram_we               = 1'b1;
          ram_waddr            = slot_idx;
          ram_wdata            = {now_q, period_q};
          valid_d[slot_idx]    = 1'b1;
          one_shot_d[slot_idx] = cmd_q == CMD_ONE_SHOT;
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_SUB: begin
        elapsed_d = add_sum;
      end
      ST_UPDATE: begin
        if (hit) begin
          ram_we = 1'b1;
          // a one-shot slot disarms itself
          ram_wdata = {add_sum, one_shot_q[idx_q] ? {TIME_W{1'b0}} : rd_period};
          for (int j = 0; j < MASK_W; j++) begin
            if (32'(idx_q) == j) begin
              mask_d[j] = 1'b1;
            end
          end
        end
        if (!last_idx) begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = mask_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      mask_q      <= '0;
      valid_q     <= '0;
      one_shot_q  <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      valid_q     <= valid_d;
      one_shot_q  <= one_shot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q    <= cmd_e'(s_axis_tdata[CMD_W-1:0]);
      slot_q   <= s_axis_tdata[CMD_W+SLOT_W-1:CMD_W];
      period_q <= s_axis_tdata[CMD_W+SLOT_W+TIME_W-1:CMD_W+SLOT_W];
      now_q    <= s_axis_tdata[CMD_W+SLOT_W+2*TIME_W-1:CMD_W+SLOT_W+TIME_W];
    end
    elapsed_q  <= elapsed_d;
    out_data_q <= out_data_d;
  end

  stb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_start_mask_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && cmd_q != CMD_TICK) |-> mask_q == '0)
    else $error("start command produced a nonzero mask");

  a_sub_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUB |=> state_q == ST_UPDATE)
    else $error("elapsed time not followed by slot update");

  a_one_shot_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit && one_shot_q[idx_q]) |-> (ram_we && ram_wdata[TIME_W-1:0] == '0))
    else $error("fired one-shot slot left armed");

  a_tick_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tdata[CMD_W-1:0] == CMD_TICK) |=> (idx_q == '0 && mask_q == '0))
    else $error("tick walk did not start at slot zero with empty mask");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && state_d == ST_IDLE) |=> m_axis_tvalid)
    else $error("finished item did not reach the output register");

endmodule

FILE: tb/timer_bank_checker.sv
`timescale 1ns / 1ps

module timer_bank_checker
  import stb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  // command[1:0], slot[4:2], period_ms[36:5], now_ms[68:37], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // fired_mask[7:0]
  input  logic [OUT_W-1:0] m_axis_tdata,
  output int               mismatches_o,
  output int               pending_o
);

  // packed from the top down, so the first field sits in the highest bits
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] period_ms;
    logic [SLOT_W-1:0] slot;
    cmd_e              command;
  } timer_cmd_t;

  logic [TIME_W-1:0] slot_period [NUM_SLOTS];
  logic [TIME_W-1:0] slot_start  [NUM_SLOTS];
  logic              slot_single [NUM_SLOTS];

  logic [MASK_W-1:0] fired_mask_q [$];
  logic [MASK_W-1:0] want_mask;
  int                mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // updates the slot copies and returns the mask of slots that fire
  function automatic logic [MASK_W-1:0] fire_slots(input timer_cmd_t w);
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] elapsed;
    mask = '0;
    case (w.command)
      CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_period[i] != '0) begin
            elapsed = w.now_ms - slot_start[i];
            if (elapsed > slot_period[i]) begin
              // one period per tick, late slots catch up on later ticks
              slot_start[i] = slot_start[i] + slot_period[i];
              if (slot_single[i]) slot_period[i] = '0;
              if (i < MASK_W) mask[i] = 1'b1;
            end
          end
        end
      end
      CMD_PERIODIC, CMD_ONE_SHOT: begin
        if (w.slot < NUM_SLOTS) begin
          slot_single[w.slot] = (w.command == CMD_ONE_SHOT);
          slot_period[w.slot] = w.period_ms;
          slot_start[w.slot]  = w.now_ms;
        end
      end
      default: ;
    endcase
    return mask;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_period[i] = '0;
        slot_start[i]  = '0;
        slot_single[i] = 1'b1;
      end
      fired_mask_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (fired_mask_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word fired_mask=%h", m_axis_tdata));
        end else begin
          want_mask = fired_mask_q.pop_front();
          if (m_axis_tdata !== want_mask)
            report_mismatch($sformatf("fired_mask got %h want %h", m_axis_tdata, want_mask));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        fired_mask_q.push_back(fire_slots(timer_cmd_t'(s_axis_tdata[IN_BITS-1:0])));
      pending_o <= fired_mask_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 384;
  localparam int HOLD_CYCLES = 300;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tready = 1'b0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [OUT_W-1:0]  m_axis_tdata;

  int                mismatches;
  int                pending;
  int                src_idle    = 0;
  int                snk_idle    = 0;
  int                stall_token = 0;
  int                seen_token  = 0;
  int                hold_left   = 0;
  logic [TIME_W-1:0] wall_ms     = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  software_timer_bank dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  timer_bank_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // receiver: random back-pressure, plus a long hold-off whenever the token moves
  always @(posedge clk_i) begin
    if (stall_token != seen_token) begin
      seen_token    <= stall_token;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // offers one word and returns at the edge where it is taken, tvalid still high
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                          input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] now);
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({now, period, slot, cmd});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly a steadily advancing clock with starts and ticks, some noise
  task automatic random_cmd();
    int                r;
    int                p;
    logic [TIME_W-1:0] period;
    r = $urandom_range(99);
    if (r < 5) begin
      send_cmd(CMD_W'($urandom_range(3)), SLOT_W'($urandom_range(7)), $urandom(), $urandom());
    end else if (r < 30) begin
      p = $urandom_range(9);
      if (p == 0) period = '0;
      else if (p == 1) period = $urandom();
      else period = $urandom_range(40, 1);
      send_cmd(CMD_W'($urandom_range(2, 1)), SLOT_W'($urandom_range(7)), period, wall_ms);
    end else begin
      p = $urandom_range(99);
      if (p == 0) wall_ms = 32'hFFFF_FF80 + $urandom_range(100);
      else if (p < 3) wall_ms = wall_ms + $urandom_range(100000, 100);
      else wall_ms = wall_ms + $urandom_range(15);
      send_cmd(CMD_TICK, SLOT_W'($urandom_range(7)), $urandom(), wall_ms);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle = 13;
    snk_idle <= 53;

    // directed: reset state, ignored code, extremes, wrap, late ticks, one-shot, restart
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd0);
    send_cmd(CMD_UNUSED,   3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_PERIODIC, 3'd0, 32'd1,        32'd0);
    send_cmd(CMD_ONE_SHOT, 3'd7, 32'd2,        32'd0);
    send_cmd(CMD_ONE_SHOT, 3'd3, 32'd0,        32'd5);
    send_cmd(CMD_PERIODIC, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_PERIODIC, 3'd6, 32'd10,       32'hFFFF_FFF8);
    send_cmd(CMD_TICK,     3'd7, 32'hFFFF_FFFF, 32'd1);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd2);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd3);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd10);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd10);
    send_cmd(CMD_PERIODIC, 3'd0, 32'd4,        32'd10);
    send_cmd(CMD_ONE_SHOT, 3'd7, 32'd3,        32'd10);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd20);
    send_cmd(CMD_PERIODIC, 3'd6, 32'd0,        32'd20);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd40);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'hFFFF_FFFF);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'hFFFF_FFFE);
    send_cmd(CMD_UNUSED,   3'd0, 32'd0,        32'd0);
    send_cmd(CMD_TICK,     3'd0, 32'd0,        32'd0);
    wall_ms = 32'd100;

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle = 53;
        snk_idle <= 13;
      end else if (phase == 2) begin
        src_idle = 0;
        snk_idle <= 0;
        // long receiver hold-off while words keep coming
        stall_token <= stall_token + 1;
      end
      repeat (PHASE_ITEMS) random_cmd();
    end
    s_axis_tvalid <= 1'b0;

    // let the checker count the last word before waiting on it
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
